/* sv/u16u8_pkg.sv */
// ----------------------------------------------------------------------------
// u16u8_pkg
// shared types and constants of the utf-16 to utf-8 transcoder
// ----------------------------------------------------------------------------
package u16u8_pkg;

	localparam int unsigned UNIT_W  = 16;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned POINT_W = 21;
	localparam int unsigned MAX_BYTES = 4;

	localparam logic [5:0] LEAD_TAG = 6'b110110;

	localparam logic [POINT_W-1:0] ONE_BYTE_LIMIT   = 21'h00080;
	localparam logic [POINT_W-1:0] TWO_BYTE_LIMIT   = 21'h00800;
	localparam logic [POINT_W-1:0] THREE_BYTE_LIMIT = 21'h10000;
	localparam logic [POINT_W-1:0] SUPP_OFFSET      = 21'h10000;

	localparam logic [BYTE_W-1:0] PREFIX_TWO   = 8'hC0;
	localparam logic [BYTE_W-1:0] PREFIX_THREE = 8'hE0;
	localparam logic [BYTE_W-1:0] PREFIX_FOUR  = 8'hF0;
	localparam logic [BYTE_W-1:0] PREFIX_CONT  = 8'h80;

	// one encoded code point waiting for the output side
	typedef struct packed {
		logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
		logic [1:0]                       last_idx;
		logic                             str_last;
	} u16u8_entry_t;

endpackage

/* sv/u16u8_front.sv */
// ----------------------------------------------------------------------------
// u16u8_front
// accepts code units, pairs surrogates and encodes each code point
// ----------------------------------------------------------------------------
module u16u8_front import u16u8_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [UNIT_W-1:0] s_tdata,   // code_unit
	input  logic              s_tlast,   // last_unit
	input  logic              q_full,
	output logic              q_push,
	output u16u8_entry_t      q_wdata
);

	logic       swap_q;
	logic       pending_q;
	logic [9:0] held_q;

	logic [UNIT_W-1:0]  unit;
	logic               is_lead;
	logic               accept;
	logic [POINT_W-1:0] point;
	logic               emit;

	function automatic u16u8_entry_t encode(input logic [POINT_W-1:0] cp, input logic fin);
		u16u8_entry_t e;
		e = '0;
		e.str_last = fin;
		if (cp < ONE_BYTE_LIMIT) begin
			e.bytes[0] = cp[7:0];
			e.last_idx = 2'd0;
		end else if (cp < TWO_BYTE_LIMIT) begin
			e.bytes[0] = PREFIX_TWO | {3'b0, cp[10:6]};
			e.bytes[1] = PREFIX_CONT | {2'b0, cp[5:0]};
			e.last_idx = 2'd1;
		end else if (cp < THREE_BYTE_LIMIT) begin
			e.bytes[0] = PREFIX_THREE | {4'b0, cp[15:12]};
			e.bytes[1] = PREFIX_CONT | {2'b0, cp[11:6]};
			e.bytes[2] = PREFIX_CONT | {2'b0, cp[5:0]};
			e.last_idx = 2'd2;
		end else begin
			e.bytes[0] = PREFIX_FOUR | {5'b0, cp[20:18]};
			e.bytes[1] = PREFIX_CONT | {2'b0, cp[17:12]};
			e.bytes[2] = PREFIX_CONT | {2'b0, cp[11:6]};
			e.bytes[3] = PREFIX_CONT | {2'b0, cp[5:0]};
			e.last_idx = 2'd3;
		end
		return e;
	endfunction

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign unit     = swap_q ? {s_tdata[7:0], s_tdata[15:8]} : s_tdata;
	assign is_lead  = (unit[15:10] == LEAD_TAG);

	always_comb begin
		if (pending_q) begin
			point = {1'b0, held_q, unit[9:0]} + SUPP_OFFSET;
			emit  = 1'b1;
		end else begin
			point = {5'b0, unit};
			emit  = !is_lead;
		end
	end

	assign q_push  = accept && emit;
	assign q_wdata = encode(point, s_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q    <= 1'b0;
			pending_q <= 1'b0;
			held_q    <= '0;
		end else begin
			if (cfg_we) begin
				swap_q <= cfg_wdata;
			end
			if (accept) begin
				if (pending_q) begin
					pending_q <= 1'b0;
					held_q    <= '0;
				end else if (is_lead) begin
					// a lead at the end of a string is dropped
					pending_q <= !s_tlast;
					held_q    <= s_tlast ? 10'd0 : unit[9:0];
				end
			end
		end
	end

endmodule

/* sv/u16u8_queue.sv */
// ----------------------------------------------------------------------------
// u16u8_queue
// short queue of encoded code points between front and back
// ----------------------------------------------------------------------------
module u16u8_queue import u16u8_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  u16u8_entry_t wdata,
	input  logic         pop,
	output u16u8_entry_t rdata,
	output logic         full,
	output logic         empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	u16u8_entry_t   mem [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [CW-1:0]  count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue read while empty");
`endif

endmodule

/* sv/u16u8_back.sv */
// ----------------------------------------------------------------------------
// u16u8_back
// serializes each encoded code point into utf-8 byte transactions
// ----------------------------------------------------------------------------
module u16u8_back import u16u8_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  u16u8_entry_t      q_rdata,
	input  logic              q_empty,
	output logic              q_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,   // out_byte
	output logic              m_tuser,   // last_byte
	output logic              m_tlast    // string_end
);

	u16u8_entry_t cur_q;
	logic [1:0]   idx_q;
	logic         busy_q;
	logic         final_byte;
	logic         done;

	assign final_byte = (idx_q == cur_q.last_idx);
	assign done       = !busy_q || (m_tready && final_byte);
	assign q_pop      = done && !q_empty;

	assign m_tvalid = busy_q;
	assign m_tdata  = cur_q.bytes[idx_q];
	assign m_tuser  = final_byte;
	assign m_tlast  = final_byte && cur_q.str_last;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (done) begin
				busy_q <= !q_empty;
				idx_q  <= '0;
			end else if (m_tready) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q <= cur_q.last_idx))
		else $error("byte index past end of code point");
	a_pop_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !m_tready) |-> !q_pop)
		else $error("entry loaded while output stalled");
`endif

endmodule

/* sv/utf16_to_utf8_transcoder_unit.sv */
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_unit
// utf-16 code unit stream in, utf-8 byte stream out
// ----------------------------------------------------------------------------
// input channel s_*: one code unit per transaction in s_tdata, s_tlast marks
// the final unit of a string. output channel m_*: one utf-8 byte per
// transaction, m_tuser set on the final byte of a code point, m_tlast on the
// final byte of a string. cfg_we writes cfg_wdata into the byte swap control
// (1 = swap the two bytes of each unit); write it only while idle.
// a lead surrogate is held and gives no bytes; the next unit completes the
// pair. a lead that ends a string is dropped.
// a code point is written into the queue, then loaded into the output
// register before its first byte is valid. the serializer sends its bytes
// one per cycle while m_tready is high; units that encode to one byte flow at
// one per cycle too. the queue of QUEUE_DEPTH code points lets the input keep
// going while the output is stalled, and s_tready drops once it is full.
// reset clears the queue, the held surrogate and the swap control.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_unit import u16u8_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,  // swap_order
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [UNIT_W-1:0] s_tdata,    // code_unit
	input  logic              s_tlast,    // last_unit
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,    // out_byte
	output logic              m_tuser,    // last_byte
	output logic              m_tlast     // string_end
);

	u16u8_entry_t q_wdata;
	u16u8_entry_t q_rdata;
	logic         q_push;
	logic         q_pop;
	logic         q_full;
	logic         q_empty;

	u16u8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	u16u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	u16u8_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_rdata  (q_rdata),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the utf-16 to utf-8 transcoder
// ----------------------------------------------------------------------------
// code units go in on the slave stream in random bursts, utf-8 bytes are
// taken from the master stream under a changing stall pattern. a scoreboard
// predicts every byte from each accepted code unit, including the byte swap
// setting, surrogate pairing, unpaired and invalid trails and a lead that
// ends a string. a directed part covers the range limits of each encoding
// length and the surrogate corner cases under both swap settings. random
// strings follow in several phases, each with its own swap setting.
// ----------------------------------------------------------------------------
module testbench import u16u8_pkg::*; ();

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 6;

	typedef struct packed {
		logic [UNIT_W-1:0] unit;
		logic              fin;
	} code_unit_t;

	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              point_end;
		logic              str_end;
	} utf8_byte_t;

	class utf8_scoreboard;
		bit         swap;
		bit         lead_held;
		logic [9:0] lead_bits;
		utf8_byte_t expected_bytes[$];
		int         errors;

		function void set_swap(bit v);
			swap = v;
		endfunction

		function void take_unit(logic [UNIT_W-1:0] raw, logic fin);
			logic [UNIT_W-1:0] unit;
			logic [20:0]       point;
			logic [BYTE_W-1:0] enc [4];
			int                n;
			utf8_byte_t        b;
			unit = swap ? {raw[7:0], raw[15:8]} : raw;
			if (lead_held) begin
				point = 21'h10000 + {1'b0, lead_bits, unit[9:0]};
				lead_held = 1'b0;
				lead_bits = '0;
			end else if (unit[15:10] == LEAD_TAG) begin
				// a lead that ends a string is dropped
				if (fin) begin
					lead_bits = '0;
				end else begin
					lead_bits = unit[9:0];
					lead_held = 1'b1;
				end
				return;
			end else begin
				point = {5'b0, unit};
			end
			if (point < 21'h80) begin
				n = 1;
				enc[0] = point[7:0];
			end else if (point < 21'h800) begin
				n = 2;
				enc[0] = PREFIX_TWO | {3'b0, point[10:6]};
				enc[1] = PREFIX_CONT | {2'b0, point[5:0]};
			end else if (point < 21'h10000) begin
				n = 3;
				enc[0] = PREFIX_THREE | {4'b0, point[15:12]};
				enc[1] = PREFIX_CONT | {2'b0, point[11:6]};
				enc[2] = PREFIX_CONT | {2'b0, point[5:0]};
			end else begin
				n = 4;
				enc[0] = PREFIX_FOUR | {5'b0, point[20:18]};
				enc[1] = PREFIX_CONT | {2'b0, point[17:12]};
				enc[2] = PREFIX_CONT | {2'b0, point[11:6]};
				enc[3] = PREFIX_CONT | {2'b0, point[5:0]};
			end
			for (int k = 0; k < n; k++) begin
				b.data = enc[k];
				b.point_end = (k == n - 1);
				b.str_end = (k == n - 1) && fin;
				expected_bytes.insert(expected_bytes.size(), b);
			end
		endfunction

		function void check_byte(logic [BYTE_W-1:0] data, logic point_end, logic str_end);
			utf8_byte_t b;
			if (expected_bytes.size() == 0) begin
				$error("unexpected byte: out_byte actual %h", data);
				errors++;
				return;
			end
			b = expected_bytes.pop_front();
			if (data !== b.data) begin
				$error("out_byte mismatch: expected %h, actual %h", b.data, data);
				errors++;
			end
			if (point_end !== b.point_end) begin
				$error("last_byte mismatch: expected %b, actual %b", b.point_end, point_end);
				errors++;
			end
			if (str_end !== b.str_end) begin
				$error("string_end mismatch: expected %b, actual %b", b.str_end, str_end);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [UNIT_W-1:0] s_tdata;
	logic              s_tlast;
	logic              m_tvalid;
	logic              m_tready;
	logic [BYTE_W-1:0] m_tdata;
	logic              m_tuser;
	logic              m_tlast;

	utf8_scoreboard sb;
	code_unit_t     stim_q[$];
	bit             cur_swap;
	int             cycle_count;

	utf16_to_utf8_transcoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_byte(m_tdata, m_tuser, m_tlast);
	end

	// receiver stall pattern: always ready, one in n, random, or n-1 in n
	initial begin
		int mode;
		int period;
		int len;
		m_tready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			period = $urandom_range(2, 6);
			len = $urandom_range(10, 80);
			for (int i = 0; i < len; i++) begin
				@(negedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= (i % period) == 0;
					2: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= (i % period) != 0;
				endcase
			end
		end
	end

	function automatic void push_unit(logic [UNIT_W-1:0] u, logic fin, bit swapped);
		code_unit_t cu;
		cu.unit = swapped ? {u[7:0], u[15:8]} : u;
		cu.fin = fin;
		stim_q.insert(stim_q.size(), cu);
	endfunction

	task automatic send_unit(code_unit_t cu);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= cu.unit;
		s_tlast <= cu.fin;
		do @(posedge clk); while (!s_tready);
		sb.take_unit(cu.unit, cu.fin);
	endtask

	task automatic play_stim();
		int burst;
		int gap;
		burst = 0;
		while (stim_q.size() > 0) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 12);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					@(negedge clk);
					s_tvalid <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
			end
			send_unit(stim_q.pop_front());
			burst--;
		end
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_swap(bit v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_swap(v);
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_swap = v;
	endtask

	task automatic build_random_strings(int target);
		int   len;
		int   kind;
		logic fin_now;
		while (stim_q.size() < target) begin
			len = $urandom_range(1, 8);
			for (int i = 0; i < len; i++) begin
				fin_now = (i == len - 1);
				kind = $urandom_range(0, 99);
				if (kind < 25) begin
					push_unit(16'($urandom_range(16'h0000, 16'h007F)), fin_now, cur_swap);
				end else if (kind < 40) begin
					push_unit(16'($urandom_range(16'h0080, 16'h07FF)), fin_now, cur_swap);
				end else if (kind < 55) begin
					if ($urandom_range(0, 1))
						push_unit(16'($urandom_range(16'h0800, 16'hD7FF)), fin_now,
							cur_swap);
					else
						push_unit(16'($urandom_range(16'hE000, 16'hFFFF)), fin_now,
							cur_swap);
				end else if (kind < 80) begin
					push_unit(16'hD800 | 16'($urandom_range(0, 1023)), 1'b0, cur_swap);
					push_unit(16'hDC00 | 16'($urandom_range(0, 1023)), fin_now, cur_swap);
				end else if (kind < 85) begin
					push_unit(16'hDC00 | 16'($urandom_range(0, 1023)), fin_now, cur_swap);
				end else if (kind < 90) begin
					// lead followed by an arbitrary unit taken as its trail
					push_unit(16'hD800 | 16'($urandom_range(0, 1023)), 1'b0, cur_swap);
					push_unit(16'($urandom_range(0, 65535)), fin_now, cur_swap);
				end else if (kind < 95) begin
					push_unit(16'hD800 | 16'($urandom_range(0, 1023)), fin_now, cur_swap);
				end else begin
					push_unit(16'($urandom_range(0, 65535)), fin_now, cur_swap);
				end
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cycle_count = 0;
		cur_swap = 1'b0;
		sb = new();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// directed, no swap
		write_swap(1'b0);
		push_unit(16'h0000, 1'b0, 1'b0);
		push_unit(16'h007F, 1'b0, 1'b0);
		push_unit(16'h0080, 1'b0, 1'b0);
		push_unit(16'h07FF, 1'b1, 1'b0);
		push_unit(16'h0800, 1'b0, 1'b0);
		push_unit(16'hFFFF, 1'b0, 1'b0);
		push_unit(16'hDC00, 1'b0, 1'b0);
		push_unit(16'hDFFF, 1'b1, 1'b0);
		push_unit(16'hD800, 1'b0, 1'b0);
		push_unit(16'hDC00, 1'b0, 1'b0);
		push_unit(16'hDBFF, 1'b0, 1'b0);
		push_unit(16'hDFFF, 1'b1, 1'b0);
		push_unit(16'hD800, 1'b1, 1'b0);
		push_unit(16'hDABC, 1'b0, 1'b0);
		push_unit(16'hDBFF, 1'b0, 1'b0);
		push_unit(16'h0041, 1'b1, 1'b0);
		push_unit(16'hD801, 1'b0, 1'b0);
		push_unit(16'h0000, 1'b1, 1'b0);
		play_stim();
		wait_drained();

		// directed, swapped byte order
		write_swap(1'b1);
		push_unit(16'h00D8, 1'b0, 1'b0);
		push_unit(16'h00DC, 1'b0, 1'b0);
		push_unit(16'h4100, 1'b0, 1'b0);
		push_unit(16'hFFFF, 1'b0, 1'b0);
		push_unit(16'h8000, 1'b0, 1'b0);
		push_unit(16'h00DB, 1'b1, 1'b0);
		play_stim();
		wait_drained();

		// random phases
		for (int phase = 0; phase < 4; phase++) begin
			write_swap(phase < 2 ? phase[0] : bit'($urandom_range(0, 1)));
			build_random_strings(24);
			play_stim();
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
